FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the voxel traversal RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("voxel traversal assertion failed");

// Next-cycle implication, checked out of reset.
`define VRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("voxel traversal assertion failed");

`endif

FILE: rtl/core/vrt_pkg.sv
// Shared types and constants of the voxel ray traversal unit.
package vrt_pkg;

    localparam int POS_FRAC_BITS_DEF    = 16;
    localparam int VOXEL_COORD_BITS_DEF = 16;

    localparam logic [31:0] DIST_SAT       = 32'hFFFF_FFFF;
    localparam logic [7:0]  MAX_DIST_RESET = 8'd10;
    localparam int          DIV_BITS       = 32;

    // Register indexes
    localparam logic REG_REACH_LIMIT = 1'b0;

    // Input actions
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PROBE   = 2'd0;
    localparam logic [1:0] KIND_HIT     = 2'd1;
    localparam logic [1:0] KIND_MISS    = 2'd2;
    localparam logic [1:0] KIND_NO_RAY  = 2'd3;

    // Entry face codes
    localparam logic [1:0] FACE_NONE = 2'b00;
    localparam logic [1:0] FACE_POS  = 2'b01;
    localparam logic [1:0] FACE_NEG  = 2'b11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_XMUL,
        ST_XSTORE,
        ST_LIM,
        ST_LIMST,
        ST_DSUB,
        ST_DSQ,
        ST_DACC,
        ST_ADV,
        ST_EMIT,
        ST_OUT
    } vrt_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } vrt_div_stat_t;

endpackage

FILE: rtl/core/vrt_divider.sv
// Restoring divider: 2^31 divided by a 16-bit magnitude, one quotient bit a cycle.
module vrt_divider
    import vrt_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [15:0]   divisor,
    output vrt_div_stat_t stat
);

    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] div_reg;
    logic [16:0] trial;
    logic        fits;

    // Shift in the next dividend bit: only the top bit of 2^31 is set
    always_comb begin
        trial = {rem_reg, (cnt_reg == 5'(DIV_BITS - 1))};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DIV_BITS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

FILE: rtl/core/vrt_multiplier.sv
// Shared 32x32 unsigned multiplier with a registered product.
module vrt_multiplier (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);

    logic [63:0] prod_reg;

    // Register every product
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign product = prod_reg;

endmodule

FILE: rtl/core/voxel_ray_traversal_unit.sv
// Top level of the voxel ray traversal unit: sequencer, state and ports.
//
// Walks a ray through a voxel grid as a query protocol. A start transaction
// (s_tuser = 0) carries origin and unit direction; the unit answers with the
// first voxel to probe or a miss. Each report transaction (s_tuser = 1)
// carries the solidity of that voxel and is answered with the next probe, a
// hit or a miss. Every input transaction yields exactly one result
// transaction. A report with no active ray answers with kind 3.
// Timing: one transaction at a time. A report steps one shared multiplier
// through the three axes for the squared-distance check. A start runs the
// shared restoring divider and a multiplier pass for the first crossing
// on each axis with a nonzero direction, then the distance check. s_tready
// is high only while the unit is idle; the result stays in the output
// register until m_tready takes it, and nothing new is accepted before
// that. Reset (aresetn low, synchronous) drops any ray, clears the walk
// state and sets the reach limit to 10 blocks. The reach limit sits at APB
// byte address 0; the user must write it only while the unit is idle, and
// the block itself does not enforce this.
`include "assert_macros.svh"
module voxel_ray_traversal_unit
    import vrt_pkg::*;
#(
    parameter int POS_FRAC_BITS    = POS_FRAC_BITS_DEF,
    parameter int VOXEL_COORD_BITS = VOXEL_COORD_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x[31:0] origin_y[63:32] origin_z[95:64] dir_x[111:96]
    // dir_y[127:112] dir_z[143:128] solid[144] zero fill[151:145]
    input  logic [151:0] s_tdata,
    // action[0]
    input  logic         s_tuser,
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_x[15:0] block_y[31:16] block_z[47:32] face_x[49:48]
    // face_y[51:50] face_z[53:52] zero fill[55:54]
    output logic [55:0]  m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int F    = POS_FRAC_BITS;
    localparam int VC   = VOXEL_COORD_BITS;
    localparam int LIMW = 8 + F;
    localparam int DW   = ((VC + F > 32) ? (VC + F) : 32) + 2;

    vrt_state_t state_reg, state_next;

    logic                 active_reg;
    logic [7:0]           max_reg;
    logic [1:0]           axis_reg;
    logic signed [31:0]   origin_reg [3];
    logic signed [15:0]   dir_reg    [3];
    logic [VC-1:0]        voxel_reg  [3];
    logic [VC-1:0]        start_reg  [3];
    logic [2:0]           sign_reg;
    logic [31:0]          unit_reg   [3];
    logic [31:0]          cross_reg  [3];
    logic [1:0]           face_reg   [3];
    logic [63:0]          lim_reg;
    logic [63:0]          sum_reg;
    logic [LIMW-1:0]      a_reg;

    logic [1:0]           out_kind_reg;
    logic [15:0]          out_block_reg [3];
    logic [1:0]           out_face_reg  [3];

    // Sequencer controls
    logic                 div_start;
    vrt_div_stat_t        div_stat;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;

    logic                 cfg_wr;
    logic                 in_acc;
    logic [LIMW-1:0]      lim_lin;
    logic [15:0]          dir_abs;
    logic                 dir_zero;
    logic [16:0]          off16, f16;
    logic [F-1:0]         frac;
    logic                 cross_ovf;
    logic signed [DW-1:0] vext, cen, oext, dd;
    logic [DW-1:0]        dabs;
    logic                 too_far;
    logic                 sum_over;
    logic                 is_start_voxel;
    logic [1:0]           min_ax;
    logic [32:0]          cross_sum;
    logic [VC-1:0]        vox_step;
    logic [VC+31:0]       blk_ext [3];

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_REACH_LIMIT) ? {24'd0, max_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_DIST_RESET;
        end else if (cfg_wr && (paddr[2] == REG_REACH_LIMIT)) begin
            max_reg <= pwdata[7:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // Shared units
    vrt_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (dir_abs),
        .stat    (div_stat)
    );

    vrt_multiplier u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    // Per-axis setup values
    assign lim_lin  = {max_reg, {F{1'b0}}};
    assign dir_zero = (dir_reg[axis_reg] == 16'sd0);
    assign dir_abs  = dir_reg[axis_reg][15] ? 16'(-dir_reg[axis_reg])
                                            : 16'(dir_reg[axis_reg]);
    assign frac     = origin_reg[axis_reg][F-1:0];

    generate
        if (F <= 16) begin : g_frac_up
            assign off16 = 17'(frac) << (16 - F);
        end else begin : g_frac_dn
            assign off16 = 17'(frac >> (F - 16));
        end
    endgenerate

    assign f16       = sign_reg[axis_reg] ? (17'h10000 - off16) : off16;
    assign cross_ovf = (mul_p[63:48] != 16'd0);

    // Voxel centre distance along the current axis
    always_comb begin
        vext    = DW'($signed(voxel_reg[axis_reg]));
        cen     = (vext <<< F) | (DW'(1) << (F - 1));
        oext    = DW'(origin_reg[axis_reg]);
        dd      = cen - oext;
        dabs    = dd[DW-1] ? DW'(-dd) : DW'(dd);
        too_far = (dabs > DW'(lim_lin));
    end

    assign sum_over = (mul_p > (lim_reg - sum_reg));

    assign is_start_voxel = (voxel_reg[0] == start_reg[0]) &&
                            (voxel_reg[1] == start_reg[1]) &&
                            (voxel_reg[2] == start_reg[2]);

    // Smallest crossing distance, ties to x then y
    always_comb begin
        if ((cross_reg[0] <= cross_reg[1]) && (cross_reg[0] <= cross_reg[2])) begin
            min_ax = 2'd0;
        end else if (cross_reg[1] <= cross_reg[2]) begin
            min_ax = 2'd1;
        end else begin
            min_ax = 2'd2;
        end
        cross_sum = 33'(cross_reg[min_ax]) + 33'(unit_reg[min_ax]);
        vox_step  = sign_reg[min_ax] ? (voxel_reg[min_ax] + VC'(1))
                                     : (voxel_reg[min_ax] - VC'(1));
    end

    // Multiplier operand select
    always_comb begin
        case (state_reg)
            ST_XMUL: begin
                mul_a = 32'(f16);
                mul_b = unit_reg[axis_reg];
            end
            ST_LIM: begin
                mul_a = 32'(lim_lin);
                mul_b = 32'(lim_lin);
            end
            default: begin
                mul_a = 32'(a_reg);
                mul_b = 32'(a_reg);
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == ACT_START) begin
                        state_next = ST_DIV_START;
                    end else if (!active_reg) begin
                        state_next = ST_OUT;
                    end else if (s_tdata[144] && !is_start_voxel) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_LIM;
                    end
                end
            end
            ST_DIV_START: begin
                if (dir_zero) begin
                    state_next = (axis_reg == 2'd2) ? ST_LIM : ST_DIV_START;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_XMUL;
                end
            end
            ST_XMUL:   state_next = ST_XSTORE;
            ST_XSTORE: state_next = (axis_reg == 2'd2) ? ST_LIM : ST_DIV_START;
            ST_LIM:    state_next = ST_LIMST;
            ST_LIMST:  state_next = ST_DSUB;
            ST_DSUB:   state_next = too_far ? ST_OUT : ST_DSQ;
            ST_DSQ:    state_next = ST_DACC;
            ST_DACC: begin
                if (sum_over) begin
                    state_next = ST_OUT;
                end else if (axis_reg == 2'd2) begin
                    state_next = ST_ADV;
                end else begin
                    state_next = ST_DSUB;
                end
            end
            ST_ADV:  state_next = ST_EMIT;
            ST_EMIT: state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Active flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_tuser == ACT_START) begin
                            active_reg <= 1'b1;
                        end else if (s_tdata[144] && !is_start_voxel) begin
                            active_reg <= 1'b0;
                        end
                    end
                end
                ST_DSUB: begin
                    if (too_far) begin
                        active_reg <= 1'b0;
                    end
                end
                ST_DACC: begin
                    if (sum_over) begin
                        active_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= '0;
            sign_reg <= '0;
            lim_reg  <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
                voxel_reg[i]  <= '0;
                start_reg[i]  <= '0;
                unit_reg[i]   <= '0;
                cross_reg[i]  <= '0;
                face_reg[i]   <= FACE_NONE;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc && (s_tuser == ACT_START)) begin
                        axis_reg <= 2'd0;
                        for (int i = 0; i < 3; i++) begin
                            origin_reg[i] <= $signed(s_tdata[32*i +: 32]);
                            dir_reg[i]    <= $signed(s_tdata[96 + 16*i +: 16]);
                            voxel_reg[i]  <= VC'(64'($signed(s_tdata[32*i +: 32])) >>> F);
                            start_reg[i]  <= VC'(64'($signed(s_tdata[32*i +: 32])) >>> F);
                            sign_reg[i]   <= !s_tdata[96 + 16*i + 15] &&
                                             (s_tdata[96 + 16*i +: 16] != 16'd0);
                            face_reg[i]   <= FACE_NONE;
                        end
                    end
                end
                ST_DIV_START: begin
                    if (dir_zero) begin
                        unit_reg[axis_reg]  <= DIST_SAT;
                        cross_reg[axis_reg] <= DIST_SAT;
                        axis_reg            <= axis_reg + 2'd1;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        unit_reg[axis_reg] <= div_stat.quotient;
                    end
                end
                ST_XSTORE: begin
                    cross_reg[axis_reg] <= cross_ovf ? DIST_SAT : mul_p[47:16];
                    axis_reg            <= axis_reg + 2'd1;
                end
                ST_LIMST: begin
                    lim_reg  <= mul_p;
                    sum_reg  <= '0;
                    axis_reg <= 2'd0;
                end
                ST_DACC: begin
                    sum_reg  <= sum_reg + mul_p;
                    axis_reg <= axis_reg + 2'd1;
                end
                ST_ADV: begin
                    voxel_reg[min_ax] <= vox_step;
                    cross_reg[min_ax] <= cross_sum[32] ? DIST_SAT : cross_sum[31:0];
                    // Mark the entry face on the stepped axis, clear the others
                    for (int i = 0; i < 3; i++) begin
                        face_reg[i] <= (2'(i) == min_ax) ?
                                       (sign_reg[min_ax] ? FACE_NEG : FACE_POS) :
                                       FACE_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Distance magnitude for the squared check
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DSUB) begin
            a_reg <= dabs[LIMW-1:0];
        end
    end

    // Sign-extend each coordinate; the output register takes the low 16 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            blk_ext[i] = (VC + 32)'($signed(voxel_reg[i]));
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else begin
            if ((state_reg == ST_OUT) && m_tready) begin
                m_tvalid <= 1'b0;
            end else if (state_next == ST_OUT && state_reg != ST_OUT) begin
                m_tvalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_next == ST_OUT && state_reg != ST_OUT) begin
            if (state_reg == ST_EMIT) begin
                out_kind_reg <= KIND_PROBE;
            end else if (state_reg != ST_IDLE) begin
                out_kind_reg <= KIND_MISS;
            end else if (!active_reg) begin
                out_kind_reg <= KIND_NO_RAY;
            end else begin
                out_kind_reg <= KIND_HIT;
            end
            for (int i = 0; i < 3; i++) begin
                if (state_reg == ST_EMIT || (state_reg == ST_IDLE && active_reg)) begin
                    out_block_reg[i] <= blk_ext[i][15:0];
                    out_face_reg[i]  <= face_reg[i];
                end else begin
                    out_block_reg[i] <= '0;
                    out_face_reg[i]  <= FACE_NONE;
                end
            end
        end
    end

    assign m_tuser = out_kind_reg;
    assign m_tdata = {2'b00, out_face_reg[2], out_face_reg[1], out_face_reg[0],
                      out_block_reg[2], out_block_reg[1], out_block_reg[0]};

    `VRT_ASSERT_IMPL(a_ready_no_result, aclk, aresetn, s_tready, !m_tvalid)
    `VRT_ASSERT_IMPL(a_miss_clean, aclk, aresetn, m_tvalid && (m_tuser == KIND_MISS), m_tdata == '0)
    `VRT_ASSERT_IMPL(a_div_seq, aclk, aresetn, div_stat.done, state_reg == ST_DIV_WAIT)

endmodule

FILE: tb/tb_voxel_ray_traversal_unit.sv
// Self-checking testbench for the voxel ray traversal unit: directed and random ray walks.
module tb_voxel_ray_traversal_unit;
    import vrt_pkg::*;

    localparam int          RUN_LIMIT  = 3_000_000;
    localparam int          DRAIN_WAIT = 200;
    localparam logic [63:0] FIX_ONE    = 64'd65536;
    localparam logic [63:0] FIX_HALF   = 64'd32768;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // origin_x[31:0] origin_y[63:32] origin_z[95:64] dir_x[111:96]
    // dir_y[127:112] dir_z[143:128] solid[144] zero fill[151:145]
    logic [151:0] s_tdata;
    // action[0]
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // block_x[15:0] block_y[31:16] block_z[47:32] face_x[49:48]
    // face_y[51:50] face_z[53:52] zero fill[55:54]
    logic [55:0]  m_tdata;
    // kind[1:0]
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    voxel_ray_traversal_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    typedef struct {
        logic [1:0]  kind;
        logic [55:0] payload;
    } voxel_answer_t;

    // Walker state mirrored from the block
    logic               ray_live;
    logic signed [15:0] cur_voxel [3];
    logic signed [15:0] first_voxel [3];
    longint             ray_org [3];
    logic               step_pos [3];
    logic [31:0]        unit_dist [3];
    logic [31:0]        cross_dist [3];
    logic [1:0]         entry_face [3];
    logic [7:0]         max_dist;

    voxel_answer_t answer_q [$];
    int  mismatches;
    int  cycles;
    int  items_sent;
    bit  calm;
    int  rdy_hold;

    // Clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("tb_voxel_ray_traversal_unit: done, errors");
            $finish;
        end
    end

    // Squared distance from origin to current voxel centre against the limit
    function automatic bit centre_in_range();
        longint unsigned lim_lin;
        longint unsigned lim;
        longint unsigned sum;
        longint unsigned a;
        longint          c;
        longint          dd;
        lim_lin = longint'(max_dist) << 16;
        lim     = lim_lin * lim_lin;
        sum     = 0;
        for (int i = 0; i < 3; i++) begin
            c  = longint'(cur_voxel[i]) * longint'(FIX_ONE) + longint'(FIX_HALF);
            dd = c - ray_org[i];
            a  = (dd < 0) ? longint'(-dd) : longint'(dd);
            if (a > lim_lin) return 1'b0;
            if (a * a > lim - sum) return 1'b0;
            sum += a * a;
        end
        return 1'b1;
    endfunction

    // Step along the axis with the smallest crossing distance
    function automatic void step_voxel();
        int ax;
        longint unsigned s;
        if (cross_dist[0] <= cross_dist[1] && cross_dist[0] <= cross_dist[2]) ax = 0;
        else if (cross_dist[1] <= cross_dist[2]) ax = 1;
        else ax = 2;
        cur_voxel[ax] = step_pos[ax] ? cur_voxel[ax] + 16'sd1 : cur_voxel[ax] - 16'sd1;
        s = longint'(cross_dist[ax]) + longint'(unit_dist[ax]);
        cross_dist[ax] = (s > longint'(DIST_SAT)) ? DIST_SAT : s[31:0];
        for (int i = 0; i < 3; i++) entry_face[i] = FACE_NONE;
        entry_face[ax] = step_pos[ax] ? FACE_NEG : FACE_POS;
    endfunction

    function automatic logic [55:0] voxel_payload();
        return {2'b00, entry_face[2], entry_face[1], entry_face[0],
                cur_voxel[2], cur_voxel[1], cur_voxel[0]};
    endfunction

    // Work out the answer for one accepted transaction
    function automatic voxel_answer_t walk_answer(input logic act, input logic [151:0] d);
        voxel_answer_t   ans;
        logic signed [31:0] o;
        logic signed [15:0] dv;
        longint unsigned ad;
        longint unsigned f;
        bit              away;
        ans.payload = '0;
        if (act == ACT_START) begin
            for (int i = 0; i < 3; i++) begin
                o  = d[32*i +: 32];
                dv = d[96+16*i +: 16];
                ray_org[i]     = o;
                cur_voxel[i]   = o[31:16];
                first_voxel[i] = o[31:16];
                entry_face[i]  = FACE_NONE;
                step_pos[i]    = dv > 0;
                if (dv == 0) begin
                    unit_dist[i]  = DIST_SAT;
                    cross_dist[i] = DIST_SAT;
                end else begin
                    ad = (dv < 0) ? longint'(-longint'(dv)) : longint'(dv);
                    unit_dist[i] = (64'd1 << 31) / ad;
                    f = step_pos[i] ? FIX_ONE - o[15:0] : longint'(o[15:0]);
                    f = (f * unit_dist[i]) >> 16;
                    cross_dist[i] = (f > longint'(DIST_SAT)) ? DIST_SAT : f[31:0];
                end
            end
            ray_live = 1'b1;
        end else if (!ray_live) begin
            ans.kind = KIND_NO_RAY;
            return ans;
        end else begin
            away = (cur_voxel[0] != first_voxel[0]) || (cur_voxel[1] != first_voxel[1])
                || (cur_voxel[2] != first_voxel[2]);
            if (d[144] && away) begin
                ray_live    = 1'b0;
                ans.kind    = KIND_HIT;
                ans.payload = voxel_payload();
                return ans;
            end
        end
        if (!centre_in_range()) begin
            ray_live = 1'b0;
            ans.kind = KIND_MISS;
            return ans;
        end
        step_voxel();
        ans.kind    = KIND_PROBE;
        ans.payload = voxel_payload();
        return ans;
    endfunction

    // Send one transaction, with an occasional gap ahead of it
    task automatic send_item(input logic act, input logic [151:0] d);
        logic rdy;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        forever begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
            if (rdy) break;
        end
        answer_q.push_back(walk_answer(act, d));
        items_sent++;
    endtask

    // Compare each result with the oldest answer, sampled mid-cycle
    always @(negedge aclk) begin
        voxel_answer_t exp_ans;
        int lo [6];
        int wd [6];
        lo = '{0, 16, 32, 48, 50, 52};
        wd = '{16, 16, 16, 2, 2, 2};
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind %0d data %h", m_tuser, m_tdata);
            end else begin
                exp_ans = answer_q.pop_front();
                if (m_tuser !== exp_ans.kind || m_tdata !== exp_ans.payload) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        if (m_tuser !== exp_ans.kind)
                            $display("kind: expected %0d got %0d", exp_ans.kind, m_tuser);
                        for (int i = 0; i < 6; i++)
                            if ((m_tdata >> lo[i]) % (1 << wd[i])
                                    !== (exp_ans.payload >> lo[i]) % (1 << wd[i]))
                                $display("field %0d (block x,y,z, face x,y,z): expected %h got %h",
                                         i, (exp_ans.payload >> lo[i]) % (1 << wd[i]),
                                         (m_tdata >> lo[i]) % (1 << wd[i]));
                    end
                end
            end
        end
    end

    // Result-side backpressure in random bursts
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rdy_hold <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Drop the input, let every answer come back, then hold for any trailing work
    task automatic drain();
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // APB write of the reach limit while idle
    task automatic set_reach_limit(input logic [7:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_REACH_LIMIT, 2'b00};
        pwdata  <= {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        max_dist = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [151:0] ray_item(input logic [31:0] ox, input logic [31:0] oy,
                                              input logic [31:0] oz, input logic [15:0] dx,
                                              input logic [15:0] dy, input logic [15:0] dz,
                                              input logic solid);
        return {7'd0, solid, dz, dy, dx, oz, oy, ox};
    endfunction

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, 40 << 16) - (20 << 16);
    endfunction

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Report solidity along the live ray until it ends or max_reports are sent
    task automatic follow_ray(input int solid_pct, input int max_reports);
        int n;
        n = 0;
        while (ray_live && n < max_reports) begin
            send_item(ACT_REPORT, ray_item($urandom, $urandom, $urandom, 16'($urandom),
                                           16'($urandom), 16'($urandom),
                                           ($urandom_range(0, 99) < solid_pct)));
            n++;
        end
    endtask

    task automatic random_ray(input int max_reports);
        send_item(ACT_START, ray_item(rand_origin(), rand_origin(), rand_origin(),
                                      rand_dir(), rand_dir(), rand_dir(),
                                      1'($urandom_range(0, 1))));
        follow_ray(12, max_reports);
    endtask

    task automatic test_no_ray();
        send_item(ACT_REPORT, '0);
        send_item(ACT_REPORT, ~152'd0);
    endtask

    task automatic test_directed_rays();
        // origin at the extremes, direction extremes and all-zero direction
        send_item(ACT_START, ray_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h7FFF,
                                      16'h8000, 16'h0, 1'b0));
        follow_ray(0, 4);
        send_item(ACT_START, ray_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                      16'h7FFF, 16'h7FFF, 16'h8000, 1'b1));
        follow_ray(0, 3);
        send_item(ACT_START, ray_item(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
        follow_ray(0, 3);
        // solid on the first probed voxel ends the walk with a hit, then no ray is live
        send_item(ACT_START, ray_item(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                                      16'h0001, 16'hFFFF, 16'h5A82, 1'b0));
        send_item(ACT_REPORT, ray_item('0, '0, '0, '0, '0, '0, 1'b1));
        send_item(ACT_REPORT, ray_item('0, '0, '0, '0, '0, '0, 1'b1));
        send_item(ACT_REPORT, '0);
        // start while a ray is live drops the old one
        send_item(ACT_START, ray_item(32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'h4000,
                                      16'h4000, 16'h4000, 1'b0));
        send_item(ACT_START, ray_item(32'h0, 32'h0, 32'h0, 16'hC000, 16'h0, 16'h4000, 1'b0));
        follow_ray(0, 2);
    endtask

    task automatic test_reach_limit();
        set_reach_limit(8'd0);
        random_ray(3);
        random_ray(3);
        set_reach_limit(8'd1);
        random_ray(20);
        set_reach_limit(8'd255);
        random_ray(30);
    endtask

    task automatic test_random_walks();
        logic [7:0] settings [5];
        settings = '{8'd10, 8'd3, 8'd1, 8'd255, 8'd17};
        for (int p = 0; p < 5; p++) begin
            set_reach_limit(settings[p]);
            while (items_sent < 280 * (p + 1)) begin
                if ($urandom_range(0, 15) == 0) send_item(ACT_REPORT, 152'({$urandom, $urandom}));
                else random_ray(settings[p] == 8'd255 ? 30 : 60);
            end
        end
    endtask

    task automatic test_calm_tail();
        calm = 1'b1;
        set_reach_limit(8'($urandom_range(2, 12)));
        while (items_sent < 1550) random_ray(40);
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        items_sent = 0;
        calm       = 1'b0;
        ray_live   = 1'b0;
        max_dist   = MAX_DIST_RESET;
        for (int i = 0; i < 3; i++) begin
            cur_voxel[i]   = '0;
            first_voxel[i] = '0;
            ray_org[i]     = 0;
            step_pos[i]    = 1'b0;
            unit_dist[i]   = '0;
            cross_dist[i]  = '0;
            entry_face[i]  = FACE_NONE;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_no_ray();
        test_directed_rays();
        test_reach_limit();
        test_random_walks();
        test_calm_tail();

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("tb_voxel_ray_traversal_unit: done, clean");
        end else begin
            $display("tb_voxel_ray_traversal_unit: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/vrt_pkg.sv
rtl/core/vrt_divider.sv
rtl/core/vrt_multiplier.sv
rtl/core/voxel_ray_traversal_unit.sv
tb/tb_voxel_ray_traversal_unit.sv
